[hw/rtl/fedt_pkg.sv]
package fedt_pkg;

  // Fixed field widths of the request and result items.
  localparam int POINT_W    = 7;
  localparam int NUM_W      = 7;
  localparam int STEP_W     = 7;
  localparam int DEG_W      = 2;
  localparam int USED_W     = 64;
  localparam int CMD_W      = 3;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 16;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_MAX_DEGREE = 2;

  // Command codes carried in the request.
  typedef enum logic [CMD_W-1:0] {
    CMD_FORCE     = 3'd0,
    CMD_IS_FORCED = 3'd1,
    CMD_FIND      = 3'd2,
    CMD_DEGREE    = 3'd3,
    CMD_UNFORCE   = 3'd4,
    CMD_CLEAR     = 3'd5
  } cmd_t;

  // Source of the point pair that addresses the edge table.
  typedef enum logic [1:0] {
    PAIR_AB  = 2'd0,
    PAIR_AK  = 2'd1,
    PAIR_LOG = 2'd2
  } pair_sel_t;

  // Point whose degree is read or written.
  typedef enum logic [1:0] {
    DEG_A = 2'd0,
    DEG_B = 2'd1,
    DEG_P = 2'd2,
    DEG_Q = 2'd3
  } deg_sel_t;

  // Kind of result to build.
  typedef enum logic [2:0] {
    RES_FAIL = 3'd0,
    RES_OK   = 3'd1,
    RES_EF   = 3'd2,
    RES_FIND = 3'd3,
    RES_DEG  = 3'd4
  } res_sel_t;

  // One edge table entry.
  typedef struct packed {
    logic              valid;
    logic [STEP_W-1:0] tag;
  } tbl_ent_t;

  // One edge log entry.
  typedef struct packed {
    logic [POINT_W-1:0] lo;
    logic [POINT_W-1:0] hi;
  } log_ent_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    pair_sel_t pair_sel;
    deg_sel_t  deg_sel;
    logic      hold_a;
    logic      tbl_set;
    logic      tbl_clr;
    logic      deg_inc;
    logic      deg_dec;
    logic      log_push;
    logic      log_keep;
    logic      idx_next;
    logic      unf_start;
    logic      unf_end;
    logic      find_start;
    logic      find_issue;
    logic      sweep_start;
    logic      sweep_step;
    logic      pend_load;
    res_sel_t  pend_sel;
    logic      out_load;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             pair_ok;
    logic             a_ok;
    logic             tbl_hit;
    logic             tag_hit;
    logic             deg_room;
    logic             a_room;
    logic             log_room;
    logic             unf_more;
    logic             find_last;
    logic             sweep_last;
    logic             out_busy;
  } sts_t;

endpackage

[hw/rtl/fedt_datapath.sv]
module fedt_datapath #(
  parameter int MAX_POINTS = fedt_pkg::DEF_MAX_POINTS,
  parameter int MAX_DEGREE = fedt_pkg::DEF_MAX_DEGREE
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fedt_pkg::ctl_t                   ctl,
  output fedt_pkg::sts_t                   sts,
  input  logic [fedt_pkg::IN_DATA_W-1:0]   in_data,
  input  logic                             cfg_fire,
  input  logic [fedt_pkg::NUM_W-1:0]       cfg_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [fedt_pkg::OUT_DATA_W-1:0]  out_data
);

  localparam int TS       = MAX_POINTS * (MAX_POINTS - 1) / 2;
  localparam int SW       = $clog2(TS);
  localparam int LOG_SIZE = MAX_POINTS * MAX_DEGREE / 2 + 1;
  localparam int LIW      = $clog2(LOG_SIZE);
  localparam int LCW      = $clog2(LOG_SIZE + 1);
  localparam int PIW      = $clog2(MAX_POINTS);
  localparam int PW       = fedt_pkg::POINT_W;
  localparam int DW       = fedt_pkg::DEG_W;
  localparam int NUM_RST  = (MAX_POINTS < 64) ? MAX_POINTS : 64;

  // Slot of an unordered pair in the triangular table.
  function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] lo, input logic [PW-1:0] hi);
    logic [31:0] prod;
    logic [31:0] s;
    prod = (32'(2 * MAX_POINTS) - 32'(lo)) * (32'(lo) - 32'd1);
    s    = (prod >> 1) + 32'(hi) - 32'(lo) - 32'd1;
    return (s < 32'(TS)) ? SW'(s) : '0;
  endfunction

  // Memory index of a point numbered from one.
  function automatic logic [PIW-1:0] pidx(input logic [PW-1:0] p);
    return PIW'(p - 7'd1);
  endfunction

  // Captured request and configuration.
  logic [PW-1:0]                  a_r, b_r;
  logic [fedt_pkg::CMD_W-1:0]     cmd_r;
  logic [fedt_pkg::STEP_W-1:0]    step_r;
  logic [fedt_pkg::USED_W-1:0]    used_r;
  logic [fedt_pkg::NUM_W-1:0]     num_r, num_nxt;

  // Memories and their registered read data.
  fedt_pkg::tbl_ent_t tbl_mem [TS];
  logic [DW-1:0]      deg_mem [MAX_POINTS];
  fedt_pkg::log_ent_t log_mem [LOG_SIZE];
  fedt_pkg::tbl_ent_t tbl_q_r;
  logic [DW-1:0]      deg_q_r;
  fedt_pkg::log_ent_t log_q_r;

  logic [SW-1:0]      slot_r;
  logic [SW-1:0]      swp_cnt_r;
  logic [LCW-1:0]     log_cnt_r, i_r, w_r;
  logic               a_room_r;

  // Neighbor search pipeline.
  logic [PW-1:0]      k_r, k1_r, k2_r;
  logic               v1_r, v2_r;
  logic               nf_r;
  logic [PW-1:0]      nb_r;

  // Pending and output result.
  logic               p_ok_r, p_ef_r, p_nf_r;
  logic [PW-1:0]      p_nb_r;
  logic [DW-1:0]      p_dc_r;
  logic               out_valid_r;
  logic [fedt_pkg::OUT_DATA_W-1:0] out_data_r;

  logic [PW-1:0]      pp, pq, lo, hi, dpt;
  logic [PIW-1:0]     deg_addr;
  logic               a_ok, b_ok, find_hit;

  // Config clamp to the supported range.
  always_comb begin
    num_nxt = cfg_data;
    if (cfg_data < 7'd2) begin
      num_nxt = 7'd2;
    end else if (32'(cfg_data) > MAX_POINTS) begin
      num_nxt = fedt_pkg::NUM_W'(MAX_POINTS);
    end
  end

  // Pair selection and ordering.
  always_comb begin
    case (ctl.pair_sel)
      fedt_pkg::PAIR_AK: begin
        pp = a_r;
        pq = k_r;
      end
      fedt_pkg::PAIR_LOG: begin
        pp = log_q_r.lo;
        pq = log_q_r.hi;
      end
      default: begin
        pp = a_r;
        pq = b_r;
      end
    endcase
    lo = (pp < pq) ? pp : pq;
    hi = (pp < pq) ? pq : pp;
  end

  // Degree address selection.
  always_comb begin
    case (ctl.deg_sel)
      fedt_pkg::DEG_B: dpt = b_r;
      fedt_pkg::DEG_P: dpt = log_q_r.lo;
      fedt_pkg::DEG_Q: dpt = log_q_r.hi;
      default:         dpt = a_r;
    endcase
    deg_addr = pidx(dpt);
  end

  assign a_ok = (a_r != '0) && (a_r <= num_r);
  assign b_ok = (b_r != '0) && (b_r <= num_r);
  assign find_hit = v2_r && tbl_q_r.valid && (k2_r != a_r) &&
                    !((k2_r <= 7'd64) && used_r[6'(k2_r - 7'd1)]);

  // Status toward the controller.
  always_comb begin
    sts.cmd        = cmd_r;
    sts.pair_ok    = a_ok && b_ok && (a_r != b_r);
    sts.a_ok       = a_ok;
    sts.tbl_hit    = tbl_q_r.valid;
    sts.tag_hit    = (tbl_q_r.tag == step_r);
    sts.deg_room   = (32'(deg_q_r) < MAX_DEGREE);
    sts.a_room     = a_room_r;
    sts.log_room   = (log_cnt_r < LCW'(LOG_SIZE));
    sts.unf_more   = (i_r < log_cnt_r);
    sts.find_last  = (k_r == num_r);
    sts.sweep_last = (swp_cnt_r == SW'(TS - 1));
    sts.out_busy   = out_valid_r && !out_ready;
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_data[2:0];
      a_r    <= in_data[9:3];
      b_r    <= in_data[16:10];
      step_r <= in_data[23:17];
      used_r <= in_data[87:24];
    end
  end

  // Point count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= fedt_pkg::NUM_W'(NUM_RST);
    end else if (cfg_fire) begin
      num_r <= num_nxt;
    end
  end

  // Slot register and table memory.
  always_ff @(posedge clk) begin
    slot_r  <= slot_of(lo, hi);
    tbl_q_r <= tbl_mem[slot_r];
    if (ctl.sweep_step) begin
      tbl_mem[swp_cnt_r] <= '0;
    end else if (ctl.tbl_set) begin
      tbl_mem[slot_r] <= '{valid: 1'b1, tag: step_r};
    end else if (ctl.tbl_clr) begin
      tbl_mem[slot_r] <= '0;
    end
  end

  // Degree memory with read-modify-write.
  always_ff @(posedge clk) begin
    deg_q_r <= deg_mem[deg_addr];
    if (ctl.sweep_step) begin
      if (32'(swp_cnt_r) < MAX_POINTS) begin
        deg_mem[PIW'(swp_cnt_r)] <= '0;
      end
    end else if (ctl.deg_inc) begin
      deg_mem[deg_addr] <= deg_q_r + 2'd1;
    end else if (ctl.deg_dec) begin
      if (deg_q_r != '0) begin
        deg_mem[deg_addr] <= deg_q_r - 2'd1;
      end
    end
    if (ctl.hold_a) begin
      a_room_r <= (32'(deg_q_r) < MAX_DEGREE);
    end
  end

  // Edge log memory.
  always_ff @(posedge clk) begin
    log_q_r <= log_mem[LIW'(i_r)];
    if (ctl.log_push) begin
      log_mem[LIW'(log_cnt_r)] <= '{lo: a_r, hi: b_r};
    end else if (ctl.log_keep) begin
      log_mem[LIW'(w_r)] <= log_q_r;
    end
  end

  // Log count and compaction pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_cnt_r <= '0;
    end else if (ctl.sweep_start) begin
      log_cnt_r <= '0;
    end else if (ctl.log_push) begin
      log_cnt_r <= log_cnt_r + 1'b1;
    end else if (ctl.unf_end) begin
      log_cnt_r <= w_r;
    end
    if (ctl.unf_start) begin
      i_r <= '0;
      w_r <= '0;
    end else begin
      if (ctl.idx_next) begin
        i_r <= i_r + 1'b1;
      end
      if (ctl.log_keep) begin
        w_r <= w_r + 1'b1;
      end
    end
  end

  // Clearing sweep counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swp_cnt_r <= '0;
    end else if (ctl.sweep_start) begin
      swp_cnt_r <= '0;
    end else if (ctl.sweep_step) begin
      swp_cnt_r <= swp_cnt_r + 1'b1;
    end
  end

  // Neighbor search: issue, table read, evaluate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.find_issue;
      v2_r <= v1_r;
    end
    k1_r <= k_r;
    k2_r <= k1_r;
    if (ctl.find_start) begin
      k_r  <= 7'd1;
      nf_r <= 1'b0;
      nb_r <= '0;
    end else begin
      if (ctl.find_issue) begin
        k_r <= k_r + 7'd1;
      end
      if (find_hit) begin
        nf_r <= 1'b1;
        nb_r <= k2_r;
      end
    end
  end

  // Pending result; a refused request carries no answers.
  always_ff @(posedge clk) begin
    if (ctl.pend_load) begin
      p_ok_r <= (ctl.pend_sel != fedt_pkg::RES_FAIL);
      p_ef_r <= (ctl.pend_sel == fedt_pkg::RES_EF) && tbl_q_r.valid;
      p_nf_r <= (ctl.pend_sel == fedt_pkg::RES_FIND) && nf_r;
      p_nb_r <= (ctl.pend_sel == fedt_pkg::RES_FIND) ? nb_r : '0;
      p_dc_r <= (ctl.pend_sel == fedt_pkg::RES_DEG) ? deg_q_r : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (ctl.out_load) begin
      out_data_r <= {4'b0, p_dc_r, p_nb_r, p_nf_r, p_ef_r, p_ok_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/fedt_ctrl.sv]
module fedt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           cfg_fire,
  input  fedt_pkg::sts_t sts,
  output fedt_pkg::ctl_t ctl
);

  typedef enum logic [24:0] {
    ST_SWEEP_BOOT = 25'h0000001,
    ST_SWEEP_CMD  = 25'h0000002,
    ST_IDLE       = 25'h0000004,
    ST_DEC        = 25'h0000008,
    ST_F1         = 25'h0000010,
    ST_F2         = 25'h0000020,
    ST_F3         = 25'h0000040,
    ST_F4         = 25'h0000080,
    ST_F5         = 25'h0000100,
    ST_Q1         = 25'h0000200,
    ST_Q2         = 25'h0000400,
    ST_Q3         = 25'h0000800,
    ST_D1         = 25'h0001000,
    ST_D2         = 25'h0002000,
    ST_NI         = 25'h0004000,
    ST_ND1        = 25'h0008000,
    ST_ND2        = 25'h0010000,
    ST_ND3        = 25'h0020000,
    ST_U1         = 25'h0040000,
    ST_U2         = 25'h0080000,
    ST_U3         = 25'h0100000,
    ST_U4         = 25'h0200000,
    ST_U5         = 25'h0400000,
    ST_U6         = 25'h0800000,
    ST_RESP       = 25'h1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP_BOOT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencing of each command.
  always_comb begin
    state_nxt    = state_r;
    ctl          = '0;
    ctl.pair_sel = fedt_pkg::PAIR_AB;
    ctl.deg_sel  = fedt_pkg::DEG_A;
    ctl.pend_sel = fedt_pkg::RES_FAIL;
    in_ready     = 1'b0;
    case (state_r)
      ST_SWEEP_BOOT: begin
        ctl.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SWEEP_CMD: begin
        ctl.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          ctl.pend_load = 1'b1;
          ctl.pend_sel  = fedt_pkg::RES_OK;
          state_nxt     = ST_RESP;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        ctl.pend_load = 1'b1;
        state_nxt     = ST_RESP;
        case (sts.cmd)
          fedt_pkg::CMD_FORCE: begin
            if (sts.pair_ok) begin
              ctl.pend_load = 1'b0;
              state_nxt     = ST_F1;
            end
          end
          fedt_pkg::CMD_IS_FORCED: begin
            if (sts.pair_ok) begin
              ctl.pend_load = 1'b0;
              state_nxt     = ST_Q1;
            end
          end
          fedt_pkg::CMD_FIND: begin
            if (sts.a_ok) begin
              ctl.pend_load  = 1'b0;
              ctl.find_start = 1'b1;
              state_nxt      = ST_NI;
            end
          end
          fedt_pkg::CMD_DEGREE: begin
            if (sts.a_ok) begin
              ctl.pend_load = 1'b0;
              state_nxt     = ST_D1;
            end
          end
          fedt_pkg::CMD_UNFORCE: begin
            ctl.pend_load = 1'b0;
            ctl.unf_start = 1'b1;
            state_nxt     = ST_U1;
          end
          fedt_pkg::CMD_CLEAR: begin
            ctl.pend_load   = 1'b0;
            ctl.sweep_start = 1'b1;
            state_nxt       = ST_SWEEP_CMD;
          end
          default: begin
            state_nxt = ST_RESP;
          end
        endcase
      end
      // Force: read both degrees and the entry, then commit if the edge is new and there is room.
      ST_F1: state_nxt = ST_F2;
      ST_F2: begin
        ctl.deg_sel = fedt_pkg::DEG_B;
        ctl.hold_a  = 1'b1;
        state_nxt   = ST_F3;
      end
      ST_F3: begin
        ctl.deg_sel   = fedt_pkg::DEG_B;
        ctl.pend_load = 1'b1;
        state_nxt     = ST_RESP;
        if (sts.tbl_hit) begin
          ctl.pend_sel = fedt_pkg::RES_OK;
        end else if (sts.a_room && sts.deg_room && sts.log_room) begin
          ctl.pend_load = 1'b0;
          ctl.tbl_set   = 1'b1;
          ctl.deg_inc   = 1'b1;
          ctl.log_push  = 1'b1;
          state_nxt     = ST_F4;
        end
      end
      ST_F4: state_nxt = ST_F5;
      ST_F5: begin
        ctl.deg_inc   = 1'b1;
        ctl.pend_load = 1'b1;
        ctl.pend_sel  = fedt_pkg::RES_OK;
        state_nxt     = ST_RESP;
      end
      // Edge query.
      ST_Q1: state_nxt = ST_Q2;
      ST_Q2: state_nxt = ST_Q3;
      ST_Q3: begin
        ctl.pend_load = 1'b1;
        ctl.pend_sel  = fedt_pkg::RES_EF;
        state_nxt     = ST_RESP;
      end
      // Degree read.
      ST_D1: state_nxt = ST_D2;
      ST_D2: begin
        ctl.pend_load = 1'b1;
        ctl.pend_sel  = fedt_pkg::RES_DEG;
        state_nxt     = ST_RESP;
      end
      // Neighbor search: one point per cycle, then drain the pipeline.
      ST_NI: begin
        ctl.pair_sel   = fedt_pkg::PAIR_AK;
        ctl.find_issue = 1'b1;
        if (sts.find_last) begin
          state_nxt = ST_ND1;
        end
      end
      ST_ND1: state_nxt = ST_ND2;
      ST_ND2: state_nxt = ST_ND3;
      ST_ND3: begin
        ctl.pend_load = 1'b1;
        ctl.pend_sel  = fedt_pkg::RES_FIND;
        state_nxt     = ST_RESP;
      end
      // Unforce: walk the log, free matching edges, compact the rest.
      ST_U1: begin
        if (sts.unf_more) begin
          state_nxt = ST_U2;
        end else begin
          ctl.unf_end   = 1'b1;
          ctl.pend_load = 1'b1;
          ctl.pend_sel  = fedt_pkg::RES_OK;
          state_nxt     = ST_RESP;
        end
      end
      ST_U2: begin
        ctl.pair_sel = fedt_pkg::PAIR_LOG;
        ctl.deg_sel  = fedt_pkg::DEG_P;
        state_nxt    = ST_U3;
      end
      ST_U3: begin
        ctl.pair_sel = fedt_pkg::PAIR_LOG;
        ctl.deg_sel  = fedt_pkg::DEG_P;
        state_nxt    = ST_U4;
      end
      ST_U4: begin
        ctl.pair_sel = fedt_pkg::PAIR_LOG;
        ctl.deg_sel  = fedt_pkg::DEG_P;
        if (sts.tbl_hit && sts.tag_hit) begin
          ctl.tbl_clr = 1'b1;
          ctl.deg_dec = 1'b1;
          state_nxt   = ST_U5;
        end else begin
          ctl.log_keep = 1'b1;
          ctl.idx_next = 1'b1;
          state_nxt    = ST_U1;
        end
      end
      ST_U5: begin
        ctl.pair_sel = fedt_pkg::PAIR_LOG;
        ctl.deg_sel  = fedt_pkg::DEG_Q;
        state_nxt    = ST_U6;
      end
      ST_U6: begin
        ctl.pair_sel = fedt_pkg::PAIR_LOG;
        ctl.deg_sel  = fedt_pkg::DEG_Q;
        ctl.deg_dec  = 1'b1;
        ctl.idx_next = 1'b1;
        state_nxt    = ST_U1;
      end
      ST_RESP: begin
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_SWEEP_BOOT;
    endcase
    // A point count write restarts the clearing pass and takes no request that cycle.
    if (cfg_fire) begin
      in_ready        = 1'b0;
      ctl.load        = 1'b0;
      ctl.sweep_start = 1'b1;
      ctl.sweep_step  = 1'b0;
      state_nxt       = ST_SWEEP_BOOT;
    end
  end

endmodule

[hw/rtl/forced_edge_degree_table_unit.sv]
// A find_neighbour request walks points 1 to num_points, an unforce walks the edge log,
// and a clear runs the clearing pass over the edge table before its result is given.
// One request is in work at a time; a result may wait in the output register meanwhile.
// Reset (rst_n low, synchronous) or a num_points write starts a clearing pass over the
// edge table and degrees; no request is taken then.
module forced_edge_degree_table_unit #(
  parameter int MAX_POINTS = fedt_pkg::DEF_MAX_POINTS,
  parameter int MAX_DEGREE = fedt_pkg::DEF_MAX_DEGREE
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // cmd[2:0], point_a[9:3], point_b[16:10], step[23:17], used_mask[87:24]
  input  logic [fedt_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // ok[0], edge_forced[1], neighbour_found[2], neighbour[9:3], degree_count[11:10]
  output logic [fedt_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fedt_pkg::NUM_W-1:0]      cfg_data
);

  fedt_pkg::ctl_t ctl;
  fedt_pkg::sts_t sts;
  logic           cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  fedt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cfg_fire (cfg_fire),
    .sts      (sts),
    .ctl      (ctl)
  );

  fedt_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_data   (in_tdata),
    .cfg_fire  (cfg_fire),
    .cfg_data  (cfg_data),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata)
  );

endmodule

[hw/rtl/fedt_checker.sv]
module fedt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fedt_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // One request at a time: no second request right after one is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // A refused request carries no answers.
  a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[11:1] == 11'd0)
    else $error("refused result carries answers");

  // A found neighbor is always a real point.
  a_found_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2] == (out_tdata[9:3] != 7'd0)))
    else $error("neighbor flag and value disagree");

endmodule

bind forced_edge_degree_table_unit fedt_checker u_chk (.*);
